// ===== rtl/core/ltc_pkg.sv =====
// ----------------------------------------------------------------------------
// ltc_pkg
// Shared types and constants of the label track confirmation table.
// ----------------------------------------------------------------------------
package ltc_pkg;

  typedef struct packed {
    logic        kind;
    logic [15:0] obj_label;
    logic [31:0] now_tick;
  } req_item_t;

  typedef struct packed {
    logic        found;
    logic [15:0] probability;
    logic        table_full;
  } rsp_item_t;

  typedef struct packed {
    logic [7:0]  confirm_threshold;
    logic [15:0] live_ticks;
  } cfg_t;

  // One table entry as it is kept in the entry memory.
  typedef struct packed {
    logic [15:0] label;
    logic [31:0] seen_tick;
    logic [15:0] hits;
  } entry_t;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic REG_CONFIRM_THRESHOLD = 1'b0;
  localparam logic REG_LIVE_TICKS        = 1'b1;

  localparam logic [7:0]  CONFIRM_THRESHOLD_RESET = 8'd3;
  localparam logic [15:0] LIVE_TICKS_RESET        = 16'd100;

  localparam logic [15:0] HITS_MAX = 16'hFFFF;
  localparam logic [15:0] PROB_MAX = 16'hFFFF;

  // Logistic sigmoid in Q0.16 for a hit distance of -11 to +11.
  localparam logic [15:0] SIG_TABLE [0:22] = '{
    16'd1,     16'd3,     16'd8,     16'd22,    16'd60,    16'd162,
    16'd439,   16'd1179,  16'd3108,  16'd7812,  16'd17625, 16'd32768,
    16'd47911, 16'd57724, 16'd62428, 16'd64357, 16'd65097, 16'd65374,
    16'd65476, 16'd65514, 16'd65528, 16'd65533, 16'd65535
  };

  function automatic logic [15:0] sig_q16(input logic [15:0] hits,
                                          input logic [7:0]  thr);
    logic signed [17:0] d;
    logic signed [17:0] s;
    logic [15:0]        r;
    d = $signed({2'b00, hits}) - $signed({10'b0, thr});
    s = d + 18'sd11;
    if (d < -18'sd11) begin
      r = 16'd0;
    end else if (d > 18'sd11) begin
      r = PROB_MAX;
    end else begin
      r = SIG_TABLE[s[4:0]];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/ltc_entry_mem.sv =====
// ----------------------------------------------------------------------------
// ltc_entry_mem
// Single-port-write, single-port-read entry memory with registered read data.
// ----------------------------------------------------------------------------
module ltc_entry_mem
  import ltc_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/ltc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ltc_cfg_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module ltc_cfg_regs
  import ltc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic reg_index;
  logic wr_strobe;

  // Registers sit on word boundaries; the word index is address bit 2.
  assign reg_index = paddr[2];
  assign wr_strobe = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.confirm_threshold <= CONFIRM_THRESHOLD_RESET;
      cfg.live_ticks        <= LIVE_TICKS_RESET;
    end else if (wr_strobe) begin
      unique case (reg_index)
        REG_CONFIRM_THRESHOLD: cfg.confirm_threshold <= pwdata[7:0];
        REG_LIVE_TICKS:        cfg.live_ticks        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_CONFIRM_THRESHOLD: prdata = {24'd0, cfg.confirm_threshold};
      REG_LIVE_TICKS:        prdata = {16'd0, cfg.live_ticks};
      default:               prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/core/ltc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ltc_ctrl
// Scan, update and aging sequencer around the entry memory.
// ----------------------------------------------------------------------------
module ltc_ctrl
  import ltc_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          req_valid,
  output logic          req_ready,
  input  req_item_t     req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output rsp_item_t     rsp,
  output logic          mem_wr_en,
  output logic [AW-1:0] mem_wr_addr,
  output entry_t        mem_wr_data,
  output logic          mem_rd_en,
  output logic [AW-1:0] mem_rd_addr,
  input  entry_t        mem_rd_data
);

  localparam int CW = AW + 1;
  localparam logic [CW-1:0] LAST_ADDR = CW'(DEPTH - 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_FINISH} state_t;

  state_t            state;
  req_item_t         item;
  logic [CW-1:0]     cnt;
  logic              rd_pend;
  logic [AW-1:0]     rd_idx;
  logic              hit_found;
  logic [AW-1:0]     hit_idx;
  logic [15:0]       hit_hits;
  logic              free_found;
  logic [AW-1:0]     free_idx;
  logic [DEPTH-1:0]  kill;
  logic [DEPTH-1:0]  valid_bits;

  logic              cur_valid;
  logic              cur_match;
  logic [31:0]       cur_dist;
  logic              cur_stale;
  logic              rsp_free;
  logic              do_write;

  // Examine the entry that was read in the previous cycle.
  always_comb begin
    cur_valid = valid_bits[rd_idx];
    cur_match = cur_valid && (mem_rd_data.label == item.obj_label);
    cur_dist  = (item.now_tick >= mem_rd_data.seen_tick) ?
                (item.now_tick - mem_rd_data.seen_tick) :
                (mem_rd_data.seen_tick - item.now_tick);
    cur_stale = cur_valid && (cur_dist > {16'd0, cfg.live_ticks});
  end

  assign req_ready   = (state == S_IDLE);
  assign mem_rd_en   = (state == S_SCAN);
  assign mem_rd_addr = cnt[AW-1:0];
  assign rsp_free    = !rsp_valid || rsp_ready;

  // The write-back happens in the finish cycle, so it never meets a read.
  always_comb begin
    do_write    = (state == S_FINISH) && rsp_free && (item.kind == KIND_ADD) &&
                  (hit_found || free_found);
    mem_wr_en   = do_write;
    mem_wr_addr = hit_found ? hit_idx : free_idx;
    mem_wr_data.label     = item.obj_label;
    mem_wr_data.seen_tick = item.now_tick;
    if (hit_found) begin
      mem_wr_data.hits = (hit_hits == HITS_MAX) ? hit_hits : hit_hits + 16'd1;
    end else begin
      mem_wr_data.hits = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rd_pend    <= 1'b0;
      rsp_valid  <= 1'b0;
      valid_bits <= '0;
    end else begin
      // In the finish cycle the result register is reloaded instead.
      if (rsp_valid && rsp_ready && (state != S_FINISH)) begin
        rsp_valid <= 1'b0;
      end
      if (rd_pend) begin
        if (!cur_valid && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= rd_idx;
        end
        if (cur_match && !hit_found) begin
          hit_found <= 1'b1;
          hit_idx   <= rd_idx;
          hit_hits  <= mem_rd_data.hits;
        end
        if (cur_stale) begin
          kill[rd_idx] <= 1'b1;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            item       <= req;
            cnt        <= '0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            kill       <= '0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_pend <= 1'b1;
          rd_idx  <= cnt[AW-1:0];
          cnt     <= cnt + CW'(1);
          if (cnt == LAST_ADDR) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          rd_pend <= 1'b0;
          state   <= S_FINISH;
        end
        S_FINISH: begin
          if (rsp_free) begin
            rsp_valid       <= 1'b1;
            rsp.found       <= hit_found;
            rsp.probability <= (item.kind == KIND_QUERY && hit_found) ?
                               sig_q16(hit_hits, cfg.confirm_threshold) : 16'd0;
            rsp.table_full  <= (item.kind == KIND_ADD) && !hit_found && !free_found;
            if (item.kind == KIND_ADD) begin
              for (int i = 0; i < DEPTH; i++) begin
                valid_bits[i] <= (valid_bits[i] && !kill[i]) ||
                                 (do_write && (mem_wr_addr == AW'(i)));
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_prob_needs_found: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.probability != 16'd0) |-> rsp.found)
    else $error("nonzero probability for an absent label");

  a_full_not_found: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.table_full) |-> !rsp.found)
    else $error("table full reported for a present label");

  a_written_is_valid: assert property (@(posedge clk) disable iff (rst)
    mem_wr_en |=> valid_bits[$past(mem_wr_addr)])
    else $error("written entry not marked valid");

  a_hit_is_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && hit_found) |-> valid_bits[hit_idx])
    else $error("matched entry is not valid");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(mem_wr_en && mem_rd_en))
    else $error("entry memory read and write overlap");

endmodule

// ===== rtl/core/label_track_confirm_table_top.sv =====
// ----------------------------------------------------------------------------
// label_track_confirm_table_top
// Table of tracked object labels with hit counts, aging and confirmation
// probability lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on req (valid/ready). An add item (kind 0) refreshes or
//   inserts its label and then ages out entries unseen for more than
//   live_ticks; a query item (kind 1) reports presence and the sigmoid of
//   hits minus confirm_threshold. Every item gives exactly one item on rsp.
//   Each item is worked in order: one entry memory read per cycle over the
//   whole table, a drain state for the read latency, then a write-back
//   state. One item is in work at a time and the next one can be taken in
//   the cycle in which the result appears.
//   The result sits in an output register; while the receiver stalls, the
//   next item is scanned and waits in its write-back cycle until the
//   register frees up.
//   Reset clears all valid bits and loads confirm_threshold = 3 and
//   live_ticks = 100. The user must write registers over the APB-style port
//   only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module label_track_confirm_table_top
  import ltc_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_item_t   req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_item_t   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  cfg_t          cfg;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  entry_t        mem_wr_data;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  entry_t        mem_rd_data;

  ltc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ltc_entry_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  ltc_ctrl #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

endmodule
